// File: hw/rtl/c_escape_sequence_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape sequence decoder
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, quiet while reset is held.
`define CESD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define CESD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CESD_ASSERT(lbl, prop, msg)
`define CESD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/cesd_pkg.sv
// ----------------------------------------------------------------------------
// cesd_pkg
// Types, character codes and helper functions of the escape decoder.
// ----------------------------------------------------------------------------
package cesd_pkg;

  // Escape phase of the decoder.
  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_ESC   = 3'd1,
    PH_OCT1  = 3'd2,
    PH_OCT2  = 3'd3,
    PH_HEX0  = 3'd4,
    PH_HEX1  = 3'd5
  } phase_t;

  // Character codes.
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_7   = 8'h37;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LB  = 8'h62;
  localparam logic [7:0] CH_LF  = 8'h66;
  localparam logic [7:0] CH_LN  = 8'h6E;
  localparam logic [7:0] CH_LR  = 8'h72;
  localparam logic [7:0] CH_LT  = 8'h74;
  localparam logic [7:0] CH_LV  = 8'h76;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;

  // Control codes that the simple escapes stand for.
  localparam logic [7:0] CC_NUL = 8'h00;
  localparam logic [7:0] CC_BEL = 8'h07;
  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_HT  = 8'h09;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_VT  = 8'h0B;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_CR  = 8'h0D;

  // Largest number of results that one request produces.
  localparam int unsigned MAX_RES = 2;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       bad_escape;
    logic       string_done;
  } result_t;

  // Everything the decoder hands to the result queue for one request.
  typedef struct packed {
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
  } dec_out_t;

  // Result queue status seen by the top level.
  typedef struct packed {
    logic [1:0] cnt;
    logic       can_take;
  } q_stat_t;

  // Decoded digit or escape with a hit flag.
  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic is_oct(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_7);
  endfunction

  function automatic hex_t hex_val(input logic [7:0] b);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if ((b >= CH_0) && (b <= CH_9)) begin
      d = b - CH_0;
      h.ok = 1'b1;
    end else if ((b >= CH_LA) && (b <= CH_LF)) begin
      d = b - CH_LA + 8'd10;
      h.ok = 1'b1;
    end else if ((b >= CH_UA) && (b <= CH_UF)) begin
      d = b - CH_UA + 8'd10;
      h.ok = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

  function automatic esc_t simple_esc(input logic [7:0] b);
    esc_t e;
    e.ok = 1'b1;
    case (b)
      CH_BSL:  e.val = CH_BSL;
      CH_LA:   e.val = CC_BEL;
      CH_LB:   e.val = CC_BS;
      CH_LF:   e.val = CC_FF;
      CH_LN:   e.val = CC_LF;
      CH_LR:   e.val = CC_CR;
      CH_LT:   e.val = CC_HT;
      CH_LV:   e.val = CC_VT;
      default: begin
        e.ok  = 1'b0;
        e.val = CC_NUL;
      end
    endcase
    return e;
  endfunction

endpackage

// File: hw/rtl/cesd_in_if.sv
// ----------------------------------------------------------------------------
// cesd_in_if
// Raw string byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cesd_in_if
  import cesd_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

// File: hw/rtl/cesd_out_if.sv
// ----------------------------------------------------------------------------
// cesd_out_if
// Decoded byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cesd_out_if
  import cesd_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       bad_escape;
  logic       string_done;

  modport source (output valid, output out_byte, output has_byte,
                  output bad_escape, output string_done, input ready);
  modport sink   (input valid, input out_byte, input has_byte,
                  input bad_escape, input string_done, output ready);
endinterface

// File: hw/rtl/c_escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// Decodes C backslash escapes in a byte stream, one raw byte per request.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload
//   in_ch    sink       in_byte[7:0], is_final
//   out_ch   source     out_byte[7:0], has_byte, bad_escape, string_done
//
// One request is taken per cycle while the queue has room; a result passes
// through the input register, then a queue slot, before out_ch shows it. A
// lone \0 followed by a plain byte yields two results: it waits for an empty
// queue and the next request waits while the second result drains, so the
// input stalls around it. Synchronous reset clears the phase machine, the
// input valid flag and the queue count. A stalled result channel fills the
// two-slot queue, then stalls requests with results; ready is from registers only.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder
  import cesd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cesd_in_if.sink    in_ch,
  cesd_out_if.source out_ch
);

`include "c_escape_sequence_decoder_assert.svh"

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_fin_r;
  logic       in_acc;
  logic       fire;
  dec_out_t   dec;
  q_stat_t    q_stat;

  // Input register: may be refilled while empty or as its request moves on to the queue.
  assign fire         = in_vld_r && q_stat.can_take;
  assign in_ch.ready  = !in_vld_r || fire;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_vld_nxt   = in_acc ? 1'b1 : (fire ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_ch.in_byte;
      in_fin_r  <= in_ch.is_final;
    end
  end

  // Escape decoding of the registered byte.
  cesd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .b     (in_byte_r),
    .fin   (in_fin_r),
    .fire  (fire),
    .dec   (dec)
  );

  // Result queue.
  cesd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (dec),
    .push      (fire),
    .stat      (q_stat),
    .out_ch    (out_ch)
  );

  // Checks.
  `CESD_ASSERT(a_q_cnt_max, q_stat.cnt <= 2'd2, "result queue overfull")
  `CESD_ASSERT(a_hold_in, (in_vld_r && !fire) |=> (in_vld_r && $stable(in_byte_r)), "request lost")
  `CESD_ASSERT(a_res_shown, (fire && (dec.n_res != 2'd0)) |=> out_ch.valid, "result not queued")
  `CESD_ASSERT(a_two_fit, (fire && (dec.n_res == 2'd2)) |-> (q_stat.cnt == 2'd0), "queue busy")

endmodule

// File: hw/rtl/cesd_decode.sv
// ----------------------------------------------------------------------------
// cesd_decode
// Escape phase machine: decodes one registered byte into up to two results.
// ----------------------------------------------------------------------------
module cesd_decode
  import cesd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] b,
  input  logic       fin,
  input  logic       fire,
  output dec_out_t   dec
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] pv_r, pv_nxt;
  logic       err_r, err_nxt;

  // State registers advance only when the request is handed to the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      pv_r    <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pv_r    <= pv_nxt;
      err_r   <= err_nxt;
    end
  end

  // Next phase and emitted bytes.
  always_comb begin
    esc_t       esc;
    hex_t       hx;
    logic       oct;
    logic [1:0] ne;
    logic [7:0] eb0;
    logic [7:0] eb1;
    logic [1:0] nres;
    logic       err_p;

    esc       = simple_esc(b);
    hx        = hex_val(b);
    oct       = is_oct(b);
    ne        = 2'd0;
    eb0       = CC_NUL;
    eb1       = CC_NUL;
    phase_nxt = PH_PLAIN;
    pv_nxt    = '0;
    err_nxt   = err_r;

    unique case (phase_r)
      PH_ESC: begin
        if (esc.ok) begin
          ne  = 2'd1;
          eb0 = esc.val;
        end else if (oct) begin
          if (fin) begin
            if (b == CH_0) begin
              ne  = 2'd1;
              eb0 = CC_NUL;
            end else begin
              err_nxt = 1'b1;
            end
          end else begin
            phase_nxt = PH_OCT1;
            pv_nxt    = {5'd0, b[2:0]};
          end
        end else if ((b == CH_X) && !fin) begin
          phase_nxt = PH_HEX0;
        end else begin
          err_nxt = 1'b1;
        end
      end
      PH_OCT1: begin
        if (oct && !fin) begin
          phase_nxt = PH_OCT2;
          pv_nxt    = {pv_r[4:0], b[2:0]};
        end else if (pv_r == 8'd0) begin
          // Lone \0: NUL, then this byte is taken as plain text.
          ne  = 2'd1;
          eb0 = CC_NUL;
          if ((b == CH_BSL) && !fin) begin
            phase_nxt = PH_ESC;
          end else begin
            ne  = 2'd2;
            eb1 = b;
          end
        end else begin
          err_nxt = 1'b1;
        end
      end
      PH_OCT2: begin
        if (oct) begin
          ne  = 2'd1;
          eb0 = {pv_r[4:0], b[2:0]};
        end else begin
          err_nxt = 1'b1;
        end
      end
      PH_HEX0: begin
        if (hx.ok && !fin) begin
          phase_nxt = PH_HEX1;
          pv_nxt    = {4'd0, hx.val};
        end else begin
          err_nxt = 1'b1;
        end
      end
      PH_HEX1: begin
        if (hx.ok) begin
          ne  = 2'd1;
          eb0 = {pv_r[3:0], hx.val};
        end else begin
          err_nxt = 1'b1;
        end
      end
      default: begin
        // Plain text; a trailing backslash passes through as itself.
        if ((b == CH_BSL) && !fin) begin
          phase_nxt = PH_ESC;
        end else begin
          ne  = 2'd1;
          eb0 = b;
        end
      end
    endcase

    // Flag reported with this request's results, before end-of-string clear.
    err_p = err_nxt;
    nres  = (fin && (ne == 2'd0)) ? 2'd1 : ne;

    dec.n_res            = nres;
    dec.res0.out_byte    = (ne != 2'd0) ? eb0 : CC_NUL;
    dec.res0.has_byte    = (ne != 2'd0);
    dec.res0.bad_escape  = err_p;
    dec.res0.string_done = fin && (nres == 2'd1);
    dec.res1.out_byte    = eb1;
    dec.res1.has_byte    = 1'b1;
    dec.res1.bad_escape  = err_p;
    dec.res1.string_done = fin;

    // The end of a string returns the machine to its reset state.
    if (fin) begin
      phase_nxt = PH_PLAIN;
      pv_nxt    = '0;
      err_nxt   = 1'b0;
    end
  end

endmodule

// File: hw/rtl/cesd_out_queue.sv
// ----------------------------------------------------------------------------
// cesd_out_queue
// Two-slot result queue; the head slot drives the result channel.
// ----------------------------------------------------------------------------
module cesd_out_queue
  import cesd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dec_out_t    push_data,
  input  logic        push,
  output q_stat_t     stat,
  cesd_out_if.source  out_ch
);

  logic [1:0] cnt_r, cnt_nxt;
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic       pop;

  assign pop = (cnt_r != 2'd0) && out_ch.ready;

  // Room is judged on the registered count and the request's result count, so
  // ready never waits on the downstream side.
  assign stat.cnt      = cnt_r;
  assign stat.can_take = ({1'b0, cnt_r} + {1'b0, push_data.n_res}) <= 3'(MAX_RES);

  // Pop first, then append the new results behind what remains.
  // A full queue only ever takes a request without results, so it is left alone.
  always_comb begin
    logic [1:0] cnt_a;
    cnt_a     = cnt_r - {1'b0, pop};
    slot0_nxt = pop ? slot1_r : slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_a;
    if (push) begin
      if (cnt_a == 2'd0) begin
        slot0_nxt = push_data.res0;
        slot1_nxt = push_data.res1;
      end else if (cnt_a == 2'd1) begin
        slot1_nxt = push_data.res0;
      end
      cnt_nxt = cnt_a + push_data.n_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.out_byte    = slot0_r.out_byte;
  assign out_ch.has_byte    = slot0_r.has_byte;
  assign out_ch.bad_escape  = slot0_r.bad_escape;
  assign out_ch.string_done = slot0_r.string_done;

endmodule
